/* rtl/core/floppy_sector_read_command_sequencer_assert.svh */
// assertion macros used by the sequencer back end
`ifndef FLOPPY_SECTOR_READ_COMMAND_SEQUENCER_ASSERT_SVH
`define FLOPPY_SECTOR_READ_COMMAND_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define FSPR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sequencer check failed");

// next-cycle implication
`define FSPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sequencer check failed");

`endif

/* rtl/core/fspr_pkg.sv */
`timescale 1ns / 1ps

package fspr_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SECTORS_PER_TRACK = 3'd0,
		CFG_HEAD_COUNT        = 3'd1,
		CFG_TRACK_COUNT       = 3'd2,
		CFG_STRETCH_SHIFT     = 3'd3,
		CFG_GAP_LENGTH        = 3'd4,
		CFG_DRIVE_SELECT      = 3'd5,
		CFG_READ_OPCODE       = 3'd6,
		CFG_DMA_READ_MODE     = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [5:0] sectors_per_track;
		logic [1:0] head_count;
		logic [7:0] track_count;
		logic       stretch_shift;
		logic [7:0] gap_length;
		logic [1:0] drive_select;
		logic [7:0] read_opcode;
		logic [7:0] dma_read_mode;
	} cfg_t;

	// decoded request handed from the front to the back
	typedef struct packed {
		logic [7:0]  cylinder;
		logic        head;
		logic [5:0]  sector;
		logic [23:0] address;
	} rec_t;

	typedef struct packed {
		logic       target;
		logic [7:0] port_number;
		logic [7:0] write_value;
		logic       last_write;
	} wr_t;

	typedef enum logic [4:0] {
		STEP_RECAL_OP   = 5'd0,
		STEP_RECAL_DRV  = 5'd1,
		STEP_SEEK_OP    = 5'd2,
		STEP_SEEK_DRV   = 5'd3,
		STEP_SEEK_CYL   = 5'd4,
		STEP_DMA_MASK   = 5'd5,
		STEP_DMA_FLIP   = 5'd6,
		STEP_DMA_MODE   = 5'd7,
		STEP_DMA_ADDR0  = 5'd8,
		STEP_DMA_ADDR1  = 5'd9,
		STEP_DMA_PAGE   = 5'd10,
		STEP_DMA_CNT0   = 5'd11,
		STEP_DMA_CNT1   = 5'd12,
		STEP_DMA_UNMASK = 5'd13,
		STEP_RD_OP      = 5'd14,
		STEP_RD_HDRV    = 5'd15,
		STEP_RD_CYL     = 5'd16,
		STEP_RD_HEAD    = 5'd17,
		STEP_RD_SECTOR  = 5'd18,
		STEP_RD_SIZE    = 5'd19,
		STEP_RD_EOT     = 5'd20,
		STEP_RD_GAP     = 5'd21,
		STEP_RD_DTL     = 5'd22
	} step_t;

	localparam logic [7:0]  OP_RECAL        = 8'h07;
	localparam logic [7:0]  OP_SEEK         = 8'h0F;
	localparam logic [7:0]  PORT_DMA_MASK   = 8'd10;
	localparam logic [7:0]  PORT_DMA_FLIP   = 8'd12;
	localparam logic [7:0]  PORT_DMA_MODE   = 8'd11;
	localparam logic [7:0]  PORT_DMA_ADDR   = 8'd4;
	localparam logic [7:0]  PORT_DMA_PAGE   = 8'h81;
	localparam logic [7:0]  PORT_DMA_COUNT  = 8'd5;
	localparam logic [7:0]  DMA_MASK_CH2    = 8'h06;
	localparam logic [7:0]  DMA_UNMASK_CH2  = 8'h02;
	localparam logic [15:0] DMA_COUNT       = 16'd511;
	localparam logic [7:0]  SIZE_CODE_512   = 8'd2;
	localparam logic [7:0]  DTL_BYTE        = 8'hFF;

	localparam cfg_t CFG_RESET = '{
		sectors_per_track: 6'd18,
		head_count:        2'd2,
		track_count:       8'd80,
		stretch_shift:     1'b0,
		gap_length:        8'd27,
		drive_select:      2'd0,
		read_opcode:       8'd230,
		dma_read_mode:     8'd70
	};

	function automatic wr_t fifo_wr(input logic [7:0] value);
		wr_t w;
		w.target      = 1'b0;
		w.port_number = 8'd0;
		w.write_value = value;
		w.last_write  = 1'b0;
		return w;
	endfunction

	function automatic wr_t dma_wr(input logic [7:0] port, input logic [7:0] value);
		wr_t w;
		w.target      = 1'b1;
		w.port_number = port;
		w.write_value = value;
		w.last_write  = 1'b0;
		return w;
	endfunction

	function automatic wr_t step_write(input step_t step, input rec_t rec, input cfg_t cfg);
		wr_t        w;
		logic [7:0] drv;
		logic [7:0] seek_cyl;
		drv      = {6'd0, cfg.drive_select};
		seek_cyl = cfg.stretch_shift ? {rec.cylinder[6:0], 1'b0} : rec.cylinder;
		case (step)
			STEP_RECAL_OP:   w = fifo_wr(OP_RECAL);
			STEP_RECAL_DRV:  w = fifo_wr(drv);
			STEP_SEEK_OP:    w = fifo_wr(OP_SEEK);
			STEP_SEEK_DRV:   w = fifo_wr(drv);
			STEP_SEEK_CYL:   w = fifo_wr(seek_cyl);
			STEP_DMA_MASK:   w = dma_wr(PORT_DMA_MASK, DMA_MASK_CH2);
			STEP_DMA_FLIP:   w = dma_wr(PORT_DMA_FLIP, cfg.dma_read_mode);
			STEP_DMA_MODE:   w = dma_wr(PORT_DMA_MODE, cfg.dma_read_mode);
			STEP_DMA_ADDR0:  w = dma_wr(PORT_DMA_ADDR, rec.address[7:0]);
			STEP_DMA_ADDR1:  w = dma_wr(PORT_DMA_ADDR, rec.address[15:8]);
			STEP_DMA_PAGE:   w = dma_wr(PORT_DMA_PAGE, rec.address[23:16]);
			STEP_DMA_CNT0:   w = dma_wr(PORT_DMA_COUNT, DMA_COUNT[7:0]);
			STEP_DMA_CNT1:   w = dma_wr(PORT_DMA_COUNT, DMA_COUNT[15:8]);
			STEP_DMA_UNMASK: w = dma_wr(PORT_DMA_MASK, DMA_UNMASK_CH2);
			STEP_RD_OP:      w = fifo_wr(cfg.read_opcode);
			STEP_RD_HDRV:    w = fifo_wr({5'd0, rec.head, cfg.drive_select});
			STEP_RD_CYL:     w = fifo_wr(rec.cylinder);
			STEP_RD_HEAD:    w = fifo_wr({7'd0, rec.head});
			STEP_RD_SECTOR:  w = fifo_wr({2'd0, rec.sector});
			STEP_RD_SIZE:    w = fifo_wr(SIZE_CODE_512);
			STEP_RD_EOT:     w = fifo_wr({2'd0, cfg.sectors_per_track});
			STEP_RD_GAP:     w = fifo_wr(cfg.gap_length);
			STEP_RD_DTL: begin
				w            = fifo_wr(DTL_BYTE);
				w.last_write = 1'b1;
			end
			default:         w = fifo_wr(8'd0);
		endcase
		return w;
	endfunction

endpackage

/* rtl/core/fspr_req_if.sv */
`timescale 1ns / 1ps

interface fspr_req_if;
	logic        valid;
	logic        ready;
	logic [15:0] sector_number;
	logic [23:0] buffer_address;

	modport source (output valid, output sector_number, output buffer_address, input ready);
	modport sink (input valid, input sector_number, input buffer_address, output ready);
endinterface

/* rtl/core/fspr_wr_if.sv */
`timescale 1ns / 1ps

interface fspr_wr_if;
	logic       valid;
	logic       ready;
	logic       target;
	logic [7:0] port_number;
	logic [7:0] write_value;
	logic       last_write;

	modport source (
		output valid, output target, output port_number, output write_value,
		output last_write, input ready
	);
	modport sink (
		input valid, input target, input port_number, input write_value,
		input last_write, output ready
	);
endinterface

/* rtl/core/fspr_queue.sv */
`timescale 1ns / 1ps

module fspr_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  fspr_pkg::rec_t  push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output fspr_pkg::rec_t  pop_data
);
	import fspr_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	rec_t            mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/core/fspr_front.sv */
`timescale 1ns / 1ps

module fspr_front (
	input  logic            clk,
	input  logic            arst_n,
	input  fspr_pkg::cfg_t  cfg,
	fspr_req_if.sink        req,
	output logic            push_valid,
	input  logic            push_ready,
	output fspr_pkg::rec_t  push_data
);
	import fspr_pkg::*;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} front_state_t;

	front_state_t state_q;
	logic [5:0]   rem_q;
	logic [15:0]  quo_q;
	logic [3:0]   cnt_q;
	logic [23:0]  addr_q;

	logic [8:0]   tracks;
	logic [14:0]  total;
	logic         req_ok;
	logic         accept;
	logic [6:0]   trial;
	logic         ge;
	logic [6:0]   diff;

	// total sectors on the disk: heads * tracks * sectors per track
	assign tracks = (cfg.head_count == 2'd2) ? {cfg.track_count, 1'b0}
		: {1'b0, cfg.track_count};
	assign total  = 15'(tracks * cfg.sectors_per_track);
	assign req_ok = (req.buffer_address != 24'd0)
		&& (cfg.head_count == 2'd1 || cfg.head_count == 2'd2)
		&& (req.sector_number < {1'b0, total});

	assign req.ready = (state_q == F_IDLE) || ((state_q == F_PUSH) && push_ready);
	assign accept    = req.valid && req.ready;

	// one quotient bit per cycle
	assign trial = {rem_q, quo_q[15]};
	assign ge    = (trial >= {1'b0, cfg.sectors_per_track});
	assign diff  = trial - {1'b0, cfg.sectors_per_track};

	assign push_valid = (state_q == F_PUSH);
	always_comb begin
		push_data.address  = addr_q;
		push_data.sector   = rem_q + 6'd1;
		if (cfg.head_count == 2'd2) begin
			push_data.cylinder = quo_q[8:1];
			push_data.head     = quo_q[0];
		end else begin
			push_data.cylinder = quo_q[7:0];
			push_data.head     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= F_PUSH;
					end
				end
				F_IDLE, F_PUSH: begin
					if (accept && req_ok) begin
						state_q <= F_DIV;
						cnt_q   <= '0;
					end else if (state_q == F_IDLE || push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req_ok) begin
			rem_q  <= '0;
			quo_q  <= req.sector_number;
			addr_q <= req.buffer_address;
		end else if (state_q == F_DIV) begin
			rem_q <= ge ? diff[5:0] : trial[5:0];
			quo_q <= {quo_q[14:0], ge};
		end
	end

endmodule

/* rtl/core/fspr_back.sv */
`timescale 1ns / 1ps

module fspr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  fspr_pkg::cfg_t  cfg,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  fspr_pkg::rec_t  pop_data,
	fspr_wr_if.source       wr
);
	import fspr_pkg::*;

	`include "floppy_sector_read_command_sequencer_assert.svh"

	logic   running_q;
	step_t  step_q;
	rec_t   rec_q;
	logic   out_valid_q;
	wr_t    out_q;
	logic   adv;
	logic   issue;
	logic   final_step;
	logic   pop;

	assign adv        = !out_valid_q || wr.ready;
	assign issue      = running_q && adv;
	assign final_step = (step_q == STEP_RD_DTL);
	assign pop        = pop_valid && (!running_q || (issue && final_step));
	assign pop_ready  = pop;

	assign wr.valid       = out_valid_q;
	assign wr.target      = out_q.target;
	assign wr.port_number = out_q.port_number;
	assign wr.write_value = out_q.write_value;
	assign wr.last_write  = out_q.last_write;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= 1'b0;
			step_q      <= STEP_RECAL_OP;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				step_q <= final_step ? STEP_RECAL_OP : step_t'(step_q + 5'd1);
			end
			if (pop) begin
				running_q <= 1'b1;
			end else if (issue && final_step) begin
				running_q <= 1'b0;
			end
			if (issue) begin
				out_valid_q <= 1'b1;
			end else if (wr.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= pop_data;
		end
		if (issue) begin
			out_q <= step_write(step_q, rec_q, cfg);
		end
	end

	`FSPR_ASSERT_SAME(a_idle_at_first_step, clk, arst_n, !running_q, step_q == STEP_RECAL_OP)
	`FSPR_ASSERT_NEXT(a_wrap_after_last, clk, arst_n, issue && final_step, step_q == STEP_RECAL_OP)
	`FSPR_ASSERT_NEXT(a_last_flag_follows, clk, arst_n, issue && final_step, wr.valid && wr.last_write)
	`FSPR_ASSERT_SAME(a_pop_at_boundary, clk, arst_n, pop, !running_q || final_step)

endmodule

/* rtl/core/floppy_sector_read_command_sequencer.sv */
`timescale 1ns / 1ps

// Floppy sector read sequencer: each request transaction (logical sector, buffer address) is
// checked against the configured geometry and split into cylinder, head and sector by a
// bit-serial divider in the front end, then queued. The back end emits 23 write transactions,
// one per cycle when the sink keeps ready high: recalibrate, seek, the channel-2 DMA setup
// and the nine-byte read command. A request with a zero buffer address, an out-of-range
// sector or an unsupported head count is consumed and produces nothing. The write count sets
// the sustained rate: the back end pops the next request as it issues the last write of the
// current one, and the front end decodes it while the current one is still being written out.
// Configuration registers may only be written while no request is in flight.

module floppy_sector_read_command_sequencer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	fspr_req_if.sink                           req,
	fspr_wr_if.source                          wr,
	input  logic                               cfg_we,
	input  logic [fspr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [fspr_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import fspr_pkg::*;

	cfg_t  cfg_q;
	logic  push_valid;
	logic  push_ready;
	rec_t  push_data;
	logic  pop_valid;
	logic  pop_ready;
	rec_t  pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SECTORS_PER_TRACK: cfg_q.sectors_per_track <= cfg_data[5:0];
				CFG_HEAD_COUNT:        cfg_q.head_count        <= cfg_data[1:0];
				CFG_TRACK_COUNT:       cfg_q.track_count       <= cfg_data[7:0];
				CFG_STRETCH_SHIFT:     cfg_q.stretch_shift     <= cfg_data[0];
				CFG_GAP_LENGTH:        cfg_q.gap_length        <= cfg_data[7:0];
				CFG_DRIVE_SELECT:      cfg_q.drive_select      <= cfg_data[1:0];
				CFG_READ_OPCODE:       cfg_q.read_opcode       <= cfg_data[7:0];
				CFG_DMA_READ_MODE:     cfg_q.dma_read_mode     <= cfg_data[7:0];
				default:               cfg_q <= cfg_q;
			endcase
		end
	end

	fspr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	fspr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	fspr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.wr        (wr)
	);

endmodule
